// ----- rtl/lzss_pkg.sv -----
// ---------------------------------------------------------------------------
// lzss_pkg
// Shared codes and result transaction type for the LZSS stream decoder.
// ---------------------------------------------------------------------------
package lzss_pkg;

   // item kinds, also used for next_kind
   localparam logic [1:0] OP_FLAG   = 2'd0;
   localparam logic [1:0] OP_LIT    = 2'd1;
   localparam logic [1:0] OP_PAIR   = 2'd2;
   localparam logic [1:0] KIND_DONE = 2'd3;

   // result status codes
   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_END   = 2'd1;
   localparam logic [1:0] ST_ORDER = 2'd2;

   localparam logic [5:0]  FLAG_BITS_FULL = 6'd32;
   localparam logic [4:0]  PAIR_LEN_BIAS  = 5'd2;
   localparam logic [31:0] TOTAL_MAX      = 32'hFFFF_FFFF;

   typedef struct packed {
      logic [7:0]  out_byte;
      logic        byte_valid;
      logic        last;
      logic [1:0]  status;
      logic [1:0]  next_kind;
      logic [31:0] bytes_out;
   } rsp_type;

   function automatic rsp_type mk_rsp(input logic [7:0] b, input logic v, input logic l,
                                      input logic [1:0] st, input logic [1:0] nk,
                                      input logic [31:0] tot);
      rsp_type r;
      r.out_byte   = b;
      r.byte_valid = v;
      r.last       = l;
      r.status     = st;
      r.next_kind  = nk;
      r.bytes_out  = tot;
      return r;
   endfunction

endpackage

// ----- rtl/lzss_ram.sv -----
// ---------------------------------------------------------------------------
// lzss_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
module lzss_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/lzss_window.sv -----
// ---------------------------------------------------------------------------
// lzss_window
// History window: write pointer, fill tracking (unwritten entries read as
// zero), and write-to-read forwarding for overlapping copies.
// ---------------------------------------------------------------------------
module lzss_window #(
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     wr_en,
   input  logic [7:0]               wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [7:0]               rd_data
);

   localparam int IdxW = $clog2(DEPTH);

   logic [IdxW-1:0] widx_ff, widx_in;
   logic            full_ff, full_in;
   logic            byp_ff, byp_in;
   logic [7:0]      byp_data_ff;
   logic            valid_ff, valid_in;
   logic [7:0]      ram_q;

   lzss_ram #(.WIDTH(8), .DEPTH(DEPTH)) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (widx_ff),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (ram_q)
   );

   always_comb begin
      widx_in  = wr_en ? widx_ff + IdxW'(1) : widx_ff;
      full_in  = full_ff | (wr_en && (widx_ff == '0));
      byp_in   = wr_en && (rd_addr == widx_ff);
      valid_in = full_ff ||
                 ((rd_addr != '0) && ((widx_ff == '0) || (rd_addr < widx_ff)));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         widx_ff <= IdxW'(1);
         full_ff <= 1'b0;
      end else begin
         widx_ff <= widx_in;
         full_ff <= full_in;
      end
      byp_ff      <= byp_in;
      byp_data_ff <= wr_data;
      valid_ff    <= valid_in;
   end

   assign rd_data = byp_ff ? byp_data_ff : (valid_ff ? ram_q : 8'd0);

endmodule

// ----- rtl/lzss_split_stream_decoder_unit.sv -----
// ---------------------------------------------------------------------------
// lzss_split_stream_decoder_unit
// LZSS split-stream decoder with a 4096-byte history window.
// ---------------------------------------------------------------------------
// Input channel req_*: one transaction per flag word, literal byte or pair
// word; req_operation names the kind. The rsp_next_kind of each result tells
// the producer which kind to send next. An out-of-order kind gets one result
// with status 2 and leaves all state unchanged.
// Result channel rsp_*: one transaction per decoded byte, or one marker
// transaction for flag words, terminators and order errors. rsp_last marks
// the final result of an input transaction.
// Timing: flag, literal, terminator and error items are accepted and their
// result is registered when they are accepted. A copy pair (2..17 bytes) is
// started and then emits one byte per cycle while rsp_stall is low; the
// window does one read and one write per byte.
// req_stall is high while a copy runs or while an unaccepted result is held.
// When rsp_stall is high the copy pauses with its result held in place.
// Reset: pointer to index 1, counters zero. There is no clearing pass:
// entries never written read back as zero, tracked by the write pointer.
// ---------------------------------------------------------------------------
module lzss_split_stream_decoder_unit #(
   parameter int WINDOW_DEPTH = 4096
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_operation,
   input  logic [31:0] req_flag_bits,
   input  logic [7:0]  req_literal_value,
   input  logic [15:0] req_pair_value,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_out_byte,
   output logic        rsp_byte_valid,
   output logic        rsp_last,
   output logic [1:0]  rsp_status,
   output logic [1:0]  rsp_next_kind,
   output logic [31:0] rsp_bytes_out
);

   import lzss_pkg::*;

   localparam int IdxW = $clog2(WINDOW_DEPTH);
   localparam logic S_IDLE = 1'b0;
   localparam logic S_COPY = 1'b1;

   logic            state_ff, state_in;
   logic [31:0]     kind_ff, kind_in;
   logic [5:0]      left_ff, left_in;
   logic            fin_ff, fin_in;
   logic [31:0]     total_ff, total_in;
   logic [IdxW-1:0] rd_ff, rd_in;
   logic [4:0]      cnt_ff, cnt_in;
   logic            rsp_valid_ff, rsp_valid_in;
   rsp_type         rsp_ff, rsp_in;

   logic            out_free;
   logic            accept;
   logic [1:0]      want;
   logic [1:0]      want_shift;
   logic [31:0]     total_inc;
   logic [11:0]     pos;
   logic            win_wr_en;
   logic [7:0]      win_wr_data;
   logic [IdxW-1:0] rd_issue;
   logic [7:0]      win_rd_data;

   lzss_window #(.DEPTH(WINDOW_DEPTH)) u_window (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (win_wr_en),
      .wr_data (win_wr_data),
      .rd_addr (rd_issue),
      .rd_data (win_rd_data)
   );

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != S_IDLE) || !out_free;
   assign accept    = req_valid && !req_stall;
   assign pos       = req_pair_value[15:4];
   assign total_inc = (total_ff == TOTAL_MAX) ? total_ff : total_ff + 32'd1;

   always_comb begin
      if (fin_ff) begin
         want = KIND_DONE;
      end else if (left_ff == '0) begin
         want = OP_FLAG;
      end else begin
         want = kind_ff[31] ? OP_LIT : OP_PAIR;
      end
      if (left_ff == 6'd1) begin
         want_shift = OP_FLAG;
      end else begin
         want_shift = kind_ff[30] ? OP_LIT : OP_PAIR;
      end
   end

   always_comb begin
      state_in     = state_ff;
      kind_in      = kind_ff;
      left_in      = left_ff;
      fin_in       = fin_ff;
      total_in     = total_ff;
      rd_in        = rd_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_in       = rsp_ff;
      win_wr_en    = 1'b0;
      win_wr_data  = req_literal_value;
      rd_issue     = rd_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               rsp_valid_in = 1'b1;
               if (req_operation != want) begin
                  rsp_in = mk_rsp(8'd0, 1'b0, 1'b1, ST_ORDER, want, total_ff);
               end else begin
                  unique case (req_operation) inside
                     OP_FLAG: begin
                        kind_in = req_flag_bits;
                        left_in = FLAG_BITS_FULL;
                        rsp_in  = mk_rsp(8'd0, 1'b0, 1'b1, ST_OK,
                                         req_flag_bits[31] ? OP_LIT : OP_PAIR, total_ff);
                     end
                     OP_LIT: begin
                        kind_in   = {kind_ff[30:0], 1'b0};
                        left_in   = left_ff - 6'd1;
                        win_wr_en = 1'b1;
                        total_in  = total_inc;
                        rsp_in    = mk_rsp(req_literal_value, 1'b1, 1'b1, ST_OK,
                                           want_shift, total_inc);
                     end
                     OP_PAIR, KIND_DONE: begin
                        kind_in = {kind_ff[30:0], 1'b0};
                        left_in = left_ff - 6'd1;
                        if (pos == '0) begin
                           fin_in = 1'b1;
                           rsp_in = mk_rsp(8'd0, 1'b0, 1'b1, ST_END, KIND_DONE, total_ff);
                        end else begin
                           rsp_valid_in = rsp_valid_ff && rsp_stall;
                           rd_issue     = IdxW'(pos);
                           rd_in        = IdxW'(pos);
                           cnt_in       = {1'b0, req_pair_value[3:0]} + PAIR_LEN_BIAS;
                           state_in     = S_COPY;
                        end
                     end
                     default: begin
                        rsp_in = mk_rsp(8'd0, 1'b0, 1'b1, ST_ORDER, want, total_ff);
                     end
                  endcase
               end
            end
         end
         S_COPY: begin
            if (out_free) begin
               win_wr_en    = 1'b1;
               win_wr_data  = win_rd_data;
               total_in     = total_inc;
               rsp_valid_in = 1'b1;
               rsp_in       = mk_rsp(win_rd_data, 1'b1, cnt_ff == 5'd1, ST_OK, want,
                                     total_inc);
               cnt_in       = cnt_ff - 5'd1;
               rd_issue     = rd_ff + IdxW'(1);
               rd_in        = rd_ff + IdxW'(1);
               if (cnt_ff == 5'd1) begin
                  state_in = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         kind_ff      <= '0;
         left_ff      <= '0;
         fin_ff       <= 1'b0;
         total_ff     <= '0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         kind_ff      <= kind_in;
         left_ff      <= left_in;
         fin_ff       <= fin_in;
         total_ff     <= total_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rd_ff  <= rd_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_out_byte   = rsp_ff.out_byte;
   assign rsp_byte_valid = rsp_ff.byte_valid;
   assign rsp_last       = rsp_ff.last;
   assign rsp_status     = rsp_ff.status;
   assign rsp_next_kind  = rsp_ff.next_kind;
   assign rsp_bytes_out  = rsp_ff.bytes_out;

   a_copy_count: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_COPY |-> cnt_ff != 5'd0)
      else $error("copy active with zero byte count");

   a_marker_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ff.byte_valid |-> rsp_ff.last)
      else $error("marker transaction not flagged last");

   a_end_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.status == ST_END |-> rsp_ff.next_kind == KIND_DONE)
      else $error("terminator without done kind");

   a_total_mono: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> total_ff >= $past(total_ff))
      else $error("byte total decreased");

endmodule
